// ===== hw/rtl/v3a_pkg.sv =====
package v3a_pkg;

  localparam int V3A_DW   = 32;
  localparam int V3A_FRAC = 16;

  typedef enum logic [3:0] {
    OP_DOT    = 4'd0,
    OP_CROSS  = 4'd1,
    OP_LENGTH = 4'd2,
    OP_NORM   = 4'd3,
    OP_SCALE  = 4'd4,
    OP_MUL    = 4'd5,
    OP_ADD    = 4'd6,
    OP_DIVS   = 4'd7,
    OP_DIVE   = 4'd8,
    OP_SUB    = 4'd9
  } v3a_op_t;

  typedef struct packed {
    logic [3:0]                action;
    logic signed [V3A_DW-1:0]  ax;
    logic signed [V3A_DW-1:0]  ay;
    logic signed [V3A_DW-1:0]  az;
    logic signed [V3A_DW-1:0]  bx;
    logic signed [V3A_DW-1:0]  by_comp;
    logic signed [V3A_DW-1:0]  bz;
    logic signed [V3A_DW-1:0]  scalar_in;
  } v3a_in_t;

  typedef struct packed {
    logic signed [V3A_DW-1:0]  rx;
    logic signed [V3A_DW-1:0]  ry;
    logic signed [V3A_DW-1:0]  rz;
    logic signed [V3A_DW-1:0]  scalar_out;
    logic                      div_error;
  } v3a_out_t;

  // context word that rides along the cell chains
  typedef struct packed {
    v3a_op_t                   action;
    logic [2:0][V3A_DW-1:0]    res_v;   // non-divide vector result
    logic [V3A_DW-1:0]         so;      // scalar result
    logic [2:0][V3A_DW-1:0]    amag;    // numerator magnitudes
    logic [2:0][V3A_DW-1:0]    dmag;    // divisor magnitudes
    logic [2:0]                neg;     // quotient sign per lane
    logic                      dzero;   // force zero quotient
  } v3a_ctx_t;

  // saturate a wide signed value to the data range
  function automatic logic [V3A_DW-1:0] v3a_sat(input logic signed [2*V3A_DW+1:0] v);
    logic [V3A_DW+2:0] hi;
    hi = v[2*V3A_DW+1:V3A_DW-1];
    if ((&hi) || !(|hi)) return v[V3A_DW-1:0];
    return v[2*V3A_DW+1] ? {1'b1, {(V3A_DW-1){1'b0}}} : {1'b0, {(V3A_DW-1){1'b1}}};
  endfunction

  function automatic logic [V3A_DW-1:0] v3a_mag(input logic signed [V3A_DW-1:0] v);
    return v[V3A_DW-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

// ===== hw/rtl/v3a_sqrt_cell.sv =====
module v3a_sqrt_cell import v3a_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   v_i,
  input  v3a_ctx_t               ctx_i,
  input  logic [2*V3A_DW-1:0]    s_i,
  input  logic [V3A_DW-1:0]      root_i,
  input  logic [V3A_DW+1:0]      rem_i,
  output logic                   v_o,
  output v3a_ctx_t               ctx_o,
  output logic [2*V3A_DW-1:0]    s_o,
  output logic [V3A_DW-1:0]      root_o,
  output logic [V3A_DW+1:0]      rem_o
);

  logic                 v_r;
  v3a_ctx_t             ctx_r;
  logic [2*V3A_DW-1:0]  s_r, s_nxt;
  logic [V3A_DW-1:0]    root_r, root_nxt;
  logic [V3A_DW+1:0]    rem_r, rem_nxt;
  logic [V3A_DW+2:0]    t, trial, diff;

  // one root bit per cell: bring down two radicand bits, try (root<<2)|1
  always_comb begin
    t     = {rem_i[V3A_DW:0], s_i[2*V3A_DW-1 -: 2]};
    trial = {1'b0, root_i, 2'b01};
    diff  = t - trial;
    s_nxt = {s_i[2*V3A_DW-3:0], 2'b00};
    if (t >= trial) begin
      rem_nxt  = diff[V3A_DW+1:0];
      root_nxt = {root_i[V3A_DW-2:0], 1'b1};
    end else begin
      rem_nxt  = t[V3A_DW+1:0];
      root_nxt = {root_i[V3A_DW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else        v_r <= v_i;
  end

  always_ff @(posedge clk) begin
    ctx_r  <= ctx_i;
    s_r    <= s_nxt;
    root_r <= root_nxt;
    rem_r  <= rem_nxt;
  end

  assign v_o    = v_r;
  assign ctx_o  = ctx_r;
  assign s_o    = s_r;
  assign root_o = root_r;
  assign rem_o  = rem_r;

endmodule

// ===== hw/rtl/v3a_div_cell.sv =====
module v3a_div_cell import v3a_pkg::*; #(
  parameter int FRAC_BITS = V3A_FRAC
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   v_i,
  input  v3a_ctx_t                               ctx_i,
  input  logic [2:0][V3A_DW+FRAC_BITS-1:0]       nq_i,
  input  logic [2:0][V3A_DW-1:0]                 rem_i,
  input  logic [2:0][V3A_DW-1:0]                 dvs_i,
  output logic                                   v_o,
  output v3a_ctx_t                               ctx_o,
  output logic [2:0][V3A_DW+FRAC_BITS-1:0]       nq_o,
  output logic [2:0][V3A_DW-1:0]                 rem_o,
  output logic [2:0][V3A_DW-1:0]                 dvs_o
);

  localparam int NQ = V3A_DW + FRAC_BITS;

  logic                          v_r;
  v3a_ctx_t                      ctx_r;
  logic [2:0][NQ-1:0]            nq_r, nq_nxt;
  logic [2:0][V3A_DW-1:0]        rem_r, rem_nxt;
  logic [2:0][V3A_DW-1:0]        dvs_r;
  logic [2:0][V3A_DW:0]          t, diff;

  // restoring division, one quotient bit per lane per cell
  // numerator shifts out at the top while quotient bits shift in below
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      t[k]    = {rem_i[k], nq_i[k][NQ-1]};
      diff[k] = t[k] - {1'b0, dvs_i[k]};
      if (t[k] >= {1'b0, dvs_i[k]}) begin
        rem_nxt[k] = diff[k][V3A_DW-1:0];
        nq_nxt[k]  = {nq_i[k][NQ-2:0], 1'b1};
      end else begin
        rem_nxt[k] = t[k][V3A_DW-1:0];
        nq_nxt[k]  = {nq_i[k][NQ-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else        v_r <= v_i;
  end

  always_ff @(posedge clk) begin
    ctx_r <= ctx_i;
    nq_r  <= nq_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_i;
  end

  assign v_o   = v_r;
  assign ctx_o = ctx_r;
  assign nq_o  = nq_r;
  assign rem_o = rem_r;
  assign dvs_o = dvs_r;

endmodule

// ===== hw/rtl/vector3_arith_unit.sv =====
// channel   | ports                      | direction | handshake
// ----------+----------------------------+-----------+------------------------------
// input     | start, busy, in_data       | in        | word taken when start && !busy
// result    | out_valid, out_data        | out       | one-cycle strobe, no back-pressure
//
// one word enters per clock; busy never rises, the whole unit is a pipeline
// an accepted word passes the input register, the multiplier stage, the sum stage,
//   the square-root cell row (one root bit per cell) and the divider cell row
//   (one quotient bit per lane per cell), then the output register that strobes the result
// reset (rst_n low, synchronous) clears only the valid bits of every stage
// results cannot be stalled, so nothing in the pipe ever waits
module vector3_arith_unit import v3a_pkg::*; #(
  parameter int FRAC_BITS = V3A_FRAC
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  v3a_in_t  in_data,
  output logic     out_valid,
  output v3a_out_t out_data
);

  localparam int DW  = V3A_DW;
  localparam int WW  = 2*DW + 2;
  localparam int NQ  = DW + FRAC_BITS;
  localparam int LAT = 2*DW + FRAC_BITS + 4;

  localparam logic [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};

  // ---------------- stage 1: input word register
  logic     v1_r;
  v3a_in_t  in1_r;
  logic     accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= accept;
  end

  always_ff @(posedge clk) begin
    in1_r <= in_data;
  end

  // ---------------- stage 2: six multipliers, operands picked by operation
  logic signed [DW-1:0]   opa [6];
  logic signed [DW-1:0]   opb [6];
  logic signed [2*DW-1:0] prod_nxt [6];
  logic signed [2*DW-1:0] prod2_r [6];
  logic                   v2_r;
  v3a_in_t                in2_r;
  v3a_op_t                op1;

  assign op1 = v3a_op_t'(in1_r.action);

  always_comb begin
    // lanes 0, 2, 4 carry x, y, z; odd lanes only serve the cross product
    opa[0] = in1_r.ax;  opb[0] = in1_r.bx;
    opa[2] = in1_r.ay;  opb[2] = in1_r.by_comp;
    opa[4] = in1_r.az;  opb[4] = in1_r.bz;
    opa[1] = '0;        opb[1] = '0;
    opa[3] = '0;        opb[3] = '0;
    opa[5] = '0;        opb[5] = '0;
    case (op1)
      OP_CROSS: begin
        opa[0] = in1_r.ay;  opb[0] = in1_r.bz;
        opa[1] = in1_r.az;  opb[1] = in1_r.by_comp;
        opa[2] = in1_r.az;  opb[2] = in1_r.bx;
        opa[3] = in1_r.ax;  opb[3] = in1_r.bz;
        opa[4] = in1_r.ax;  opb[4] = in1_r.by_comp;
        opa[5] = in1_r.ay;  opb[5] = in1_r.bx;
      end
      OP_SCALE: begin
        opb[0] = in1_r.scalar_in;
        opb[2] = in1_r.scalar_in;
        opb[4] = in1_r.scalar_in;
      end
      OP_LENGTH, OP_NORM: begin
        // squares of the first vector feed the length
        opb[0] = in1_r.ax;
        opb[2] = in1_r.ay;
        opb[4] = in1_r.az;
      end
      default: begin
      end
    endcase
    for (int k = 0; k < 6; k++) prod_nxt[k] = opa[k] * opb[k];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    in2_r <= in1_r;
    for (int k = 0; k < 6; k++) prod2_r[k] <= prod_nxt[k];
  end

  // ---------------- stage 3: sums, floor shift, saturation, divide setup
  v3a_op_t                op2;
  logic signed [WW-1:0]   dot_w;
  logic signed [WW-1:0]   crs_w [3];
  logic signed [WW-1:0]   mul_w [3];
  logic signed [WW-1:0]   add_w [3];
  logic signed [WW-1:0]   sub_w [3];
  logic signed [DW-1:0]   a2 [3];
  logic signed [DW-1:0]   b2 [3];
  logic signed [DW-1:0]   d2 [3];
  logic [2*DW-1:0]        ssq_nxt;
  v3a_ctx_t               ctx_nxt;
  logic                   v3_r;
  v3a_ctx_t               ctx3_r;
  logic [2*DW-1:0]        ssq3_r;

  assign op2 = v3a_op_t'(in2_r.action);

  always_comb begin
    a2[0] = in2_r.ax;  a2[1] = in2_r.ay;       a2[2] = in2_r.az;
    b2[0] = in2_r.bx;  b2[1] = in2_r.by_comp;  b2[2] = in2_r.bz;

    // exact sum then floor by arithmetic shift, same as splitting high/low parts
    dot_w = (WW'(prod2_r[0]) + WW'(prod2_r[2]) + WW'(prod2_r[4])) >>> FRAC_BITS;
    // squares are never negative, so the unsigned sum fits 2*DW bits
    ssq_nxt = $unsigned(prod2_r[0]) + $unsigned(prod2_r[2]) + $unsigned(prod2_r[4]);

    ctx_nxt        = '0;
    ctx_nxt.action = op2;
    for (int k = 0; k < 3; k++) begin
      crs_w[k] = (WW'(prod2_r[2*k]) - WW'(prod2_r[2*k+1])) >>> FRAC_BITS;
      mul_w[k] = WW'(prod2_r[2*k]) >>> FRAC_BITS;
      add_w[k] = WW'(a2[k]) + WW'(b2[k]);
      sub_w[k] = WW'(a2[k]) - WW'(b2[k]);
      d2[k]    = (op2 == OP_DIVE) ? b2[k] : in2_r.scalar_in;
      ctx_nxt.amag[k] = v3a_mag(a2[k]);
      ctx_nxt.dmag[k] = v3a_mag(d2[k]);
      // normalize divides by a positive length
      ctx_nxt.neg[k]  = a2[k][DW-1] ^ ((op2 != OP_NORM) && d2[k][DW-1]);
    end

    case (op2)
      OP_DOT:   ctx_nxt.so = v3a_sat(dot_w);
      OP_CROSS: for (int k = 0; k < 3; k++) ctx_nxt.res_v[k] = v3a_sat(crs_w[k]);
      OP_SCALE,
      OP_MUL:   for (int k = 0; k < 3; k++) ctx_nxt.res_v[k] = v3a_sat(mul_w[k]);
      OP_ADD:   for (int k = 0; k < 3; k++) ctx_nxt.res_v[k] = v3a_sat(add_w[k]);
      OP_SUB:   for (int k = 0; k < 3; k++) ctx_nxt.res_v[k] = v3a_sat(sub_w[k]);
      OP_DIVS:  ctx_nxt.dzero = (in2_r.scalar_in == '0);
      OP_DIVE:  ctx_nxt.dzero = (b2[0] == '0) || (b2[1] == '0) || (b2[2] == '0);
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    ctx3_r <= ctx_nxt;
    ssq3_r <= ssq_nxt;
  end

  // ---------------- square-root cell row
  logic             sq_v    [0:DW];
  v3a_ctx_t         sq_ctx  [0:DW];
  logic [2*DW-1:0]  sq_s    [0:DW];
  logic [DW-1:0]    sq_root [0:DW];
  logic [DW+1:0]    sq_rem  [0:DW];

  assign sq_v[0]    = v3_r;
  assign sq_ctx[0]  = ctx3_r;
  assign sq_s[0]    = ssq3_r;
  assign sq_root[0] = '0;
  assign sq_rem[0]  = '0;

  for (genvar i = 0; i < DW; i++) begin : g_sqrt
    v3a_sqrt_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .v_i    (sq_v[i]),
      .ctx_i  (sq_ctx[i]),
      .s_i    (sq_s[i]),
      .root_i (sq_root[i]),
      .rem_i  (sq_rem[i]),
      .v_o    (sq_v[i+1]),
      .ctx_o  (sq_ctx[i+1]),
      .s_o    (sq_s[i+1]),
      .root_o (sq_root[i+1]),
      .rem_o  (sq_rem[i+1])
    );
  end

  // ---------------- divider entry: length is known, pick divisors
  logic [DW-1:0]           len;
  v3a_ctx_t                dctx0;
  logic [2:0][NQ-1:0]      dnq0;
  logic [2:0][DW-1:0]      ddvs0;

  assign len = sq_root[DW];

  always_comb begin
    dctx0 = sq_ctx[DW];
    if (dctx0.action == OP_LENGTH) dctx0.so = len[DW-1] ? SMAX : len;
    // a zero vector normalizes to zero without an error
    if (dctx0.action == OP_NORM) dctx0.dzero = (len == '0);
    for (int k = 0; k < 3; k++) begin
      dnq0[k]  = {dctx0.amag[k], {FRAC_BITS{1'b0}}};
      ddvs0[k] = (dctx0.action == OP_NORM) ? len : dctx0.dmag[k];
    end
  end

  // ---------------- divider cell row
  logic                 dv_v   [0:NQ];
  v3a_ctx_t             dv_ctx [0:NQ];
  logic [2:0][NQ-1:0]   dv_nq  [0:NQ];
  logic [2:0][DW-1:0]   dv_rem [0:NQ];
  logic [2:0][DW-1:0]   dv_dvs [0:NQ];

  assign dv_v[0]   = sq_v[DW];
  assign dv_ctx[0] = dctx0;
  assign dv_nq[0]  = dnq0;
  assign dv_rem[0] = '0;
  assign dv_dvs[0] = ddvs0;

  for (genvar i = 0; i < NQ; i++) begin : g_div
    v3a_div_cell #(
      .FRAC_BITS (FRAC_BITS)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .v_i   (dv_v[i]),
      .ctx_i (dv_ctx[i]),
      .nq_i  (dv_nq[i]),
      .rem_i (dv_rem[i]),
      .dvs_i (dv_dvs[i]),
      .v_o   (dv_v[i+1]),
      .ctx_o (dv_ctx[i+1]),
      .nq_o  (dv_nq[i+1]),
      .rem_o (dv_rem[i+1]),
      .dvs_o (dv_dvs[i+1])
    );
  end

  // ---------------- result select and output register
  v3a_ctx_t            fctx;
  logic [NQ:0]         qe [3];
  logic [NQ:0]         qs [3];
  logic [NQ-DW+1:0]    qhi [3];
  logic [2:0][DW-1:0]  qv;
  logic [2:0][DW-1:0]  vec;
  logic                is_div;
  v3a_out_t            out_nxt;
  logic                out_valid_r;
  v3a_out_t            out_r;

  assign fctx = dv_ctx[NQ];

  always_comb begin
    // signed quotient, truncated toward zero, then saturated
    for (int k = 0; k < 3; k++) begin
      qe[k]  = {1'b0, dv_nq[NQ][k]};
      qs[k]  = fctx.neg[k] ? (~qe[k] + 1'b1) : qe[k];
      qhi[k] = qs[k][NQ:DW-1];
      if ((&qhi[k]) || !(|qhi[k])) qv[k] = qs[k][DW-1:0];
      else                         qv[k] = qs[k][NQ] ? ~SMAX : SMAX;
    end

    is_div = (fctx.action == OP_NORM) || (fctx.action == OP_DIVS) ||
             (fctx.action == OP_DIVE);
    if (is_div) vec = fctx.dzero ? '0 : qv;
    else        vec = fctx.res_v;

    out_nxt.rx         = vec[0];
    out_nxt.ry         = vec[1];
    out_nxt.rz         = vec[2];
    out_nxt.scalar_out = fctx.so;
    out_nxt.div_error  = fctx.dzero &&
                         ((fctx.action == OP_DIVS) || (fctx.action == OP_DIVE));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= dv_v[NQ];
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ---------------- checks
  // every accepted word later comes out as a result strobe, at the delay set by LAT
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_valid)
    else $error("accepted word did not emerge on time");

  // no strobe without a matching accept
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT))
    else $error("result strobe without an accepted word");

  // a divide error always clears the result fields
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.div_error) |->
      (out_data.rx == '0 && out_data.ry == '0 && out_data.rz == '0 &&
       out_data.scalar_out == '0))
    else $error("divide error with nonzero result");

endmodule

// ===== sim/vector3_arith_unit_test.sv =====
`timescale 1ns / 100ps

module vector3_arith_unit_test;
  import v3a_pkg::*;

  typedef logic signed [127:0] wide_t;

  localparam wide_t W_MAX = 128'sd2147483647;
  localparam wide_t W_MIN = -128'sd2147483648;
  localparam wide_t W_ONE = 128'sd65536;
  localparam int    PIPE_DEPTH = 2 * V3A_DW + V3A_FRAC + 4;
  localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;
  localparam logic [31:0] Q_ONE = 32'h0001_0000;

  // one directed row: the word, and a hand-typed result where it is obvious
  typedef struct {
    v3a_in_t  word;
    bit       typed;
    v3a_out_t result;
  } vec_row_t;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  v3a_in_t  in_data;
  logic     out_valid;
  v3a_out_t out_data;

  v3a_out_t pending_results[$];
  vec_row_t directed_rows[$];
  int       mismatches;
  int       idle_pct;

  vector3_arith_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // saturate to the signed data range
  function automatic logic [31:0] clamp_q(input wide_t v);
    if (v > W_MAX) return Q_MAX;
    if (v < W_MIN) return Q_MIN;
    return v[31:0];
  endfunction

  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // what the unit should return for one word
  function automatic v3a_out_t vector_result(input v3a_in_t w);
    wide_t       a [3];
    wide_t       b [3];
    wide_t       s;
    wide_t       len_w;
    logic [63:0] len;
    v3a_out_t    r;
    a[0] = w.ax; a[1] = w.ay; a[2] = w.az;
    b[0] = w.bx; b[1] = w.by_comp; b[2] = w.bz;
    s = w.scalar_in;
    r = '0;
    case (w.action)
      OP_DOT: begin
        r.scalar_out = clamp_q((a[0] * b[0] + a[1] * b[1] + a[2] * b[2]) >>> V3A_FRAC);
      end
      OP_CROSS: begin
        r.rx = clamp_q((a[1] * b[2] - a[2] * b[1]) >>> V3A_FRAC);
        r.ry = clamp_q((a[2] * b[0] - a[0] * b[2]) >>> V3A_FRAC);
        r.rz = clamp_q((a[0] * b[1] - a[1] * b[0]) >>> V3A_FRAC);
      end
      OP_LENGTH, OP_NORM: begin
        len = root_floor(64'(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]));
        len_w = len;
        if (w.action == OP_LENGTH) begin
          r.scalar_out = clamp_q(len_w);
        end else if (len != 0) begin
          // quotient truncates toward zero
          r.rx = clamp_q((a[0] * W_ONE) / len_w);
          r.ry = clamp_q((a[1] * W_ONE) / len_w);
          r.rz = clamp_q((a[2] * W_ONE) / len_w);
        end
      end
      OP_SCALE: begin
        r.rx = clamp_q((a[0] * s) >>> V3A_FRAC);
        r.ry = clamp_q((a[1] * s) >>> V3A_FRAC);
        r.rz = clamp_q((a[2] * s) >>> V3A_FRAC);
      end
      OP_MUL: begin
        r.rx = clamp_q((a[0] * b[0]) >>> V3A_FRAC);
        r.ry = clamp_q((a[1] * b[1]) >>> V3A_FRAC);
        r.rz = clamp_q((a[2] * b[2]) >>> V3A_FRAC);
      end
      OP_ADD: begin
        r.rx = clamp_q(a[0] + b[0]);
        r.ry = clamp_q(a[1] + b[1]);
        r.rz = clamp_q(a[2] + b[2]);
      end
      OP_DIVS: begin
        if (s == 0) begin
          r.div_error = 1'b1;
        end else begin
          r.rx = clamp_q((a[0] * W_ONE) / s);
          r.ry = clamp_q((a[1] * W_ONE) / s);
          r.rz = clamp_q((a[2] * W_ONE) / s);
        end
      end
      OP_DIVE: begin
        if (b[0] == 0 || b[1] == 0 || b[2] == 0) begin
          r.div_error = 1'b1;
        end else begin
          r.rx = clamp_q((a[0] * W_ONE) / b[0]);
          r.ry = clamp_q((a[1] * W_ONE) / b[1]);
          r.rz = clamp_q((a[2] * W_ONE) / b[2]);
        end
      end
      OP_SUB: begin
        r.rx = clamp_q(a[0] - b[0]);
        r.ry = clamp_q(a[1] - b[1]);
        r.rz = clamp_q(a[2] - b[2]);
      end
      default: ;  // undefined codes give an all-zero word
    endcase
    return r;
  endfunction

  function automatic v3a_in_t make_word(input logic [3:0] op,
                                        input logic [31:0] ax, ay, az, bx, by, bz, sc);
    v3a_in_t w;
    w.action = op;
    w.ax = ax; w.ay = ay; w.az = az;
    w.bx = bx; w.by_comp = by; w.bz = bz;
    w.scalar_in = sc;
    return w;
  endfunction

  task automatic add_row(input v3a_in_t w, input bit typed, input v3a_out_t res);
    vec_row_t row;
    row.word = w;
    row.typed = typed;
    row.result = res;
    directed_rows.push_back(row);
  endtask

  // small magnitudes so the arithmetic stays in range, plus corners and full-range values
  function automatic logic [31:0] pick_comp();
    case ($urandom_range(9))
      0:       return 32'h0;
      1:       return Q_MAX;
      2:       return Q_MIN;
      3, 4, 5: return 32'($signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000);
      6:       return $urandom_range(1) ? Q_ONE : -Q_ONE;
      default: return $urandom;
    endcase
  endfunction

  function automatic v3a_in_t random_word();
    logic [3:0] op;
    v3a_in_t    w;
    op = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 10)) : 4'($urandom_range(9));
    w = make_word(op, pick_comp(), pick_comp(), pick_comp(), pick_comp(), pick_comp(),
                  pick_comp(), pick_comp());
    // keep divisors mostly nonzero so the quotient path gets real traffic
    if (op == OP_DIVS && w.scalar_in == 0 && $urandom_range(3) != 0) w.scalar_in = Q_ONE;
    if (op == OP_DIVE && $urandom_range(3) != 0) begin
      if (w.bx == 0) w.bx = 32'h0000_8000;
      if (w.by_comp == 0) w.by_comp = -Q_ONE;
      if (w.bz == 0) w.bz = 32'h1;
    end
    return w;
  endfunction

  // present one word, hold it until taken, then log what must come back
  task automatic send_word(input v3a_in_t w, input v3a_out_t res);
    int gap;
    gap = 0;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct && gap < 40) begin
      start <= 1'b0;
      @(posedge clk);
      gap++;
    end
    start   <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(res);
  endtask

  // result check, oldest expectation first
  always @(posedge clk) begin
    v3a_out_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", out_data);
      end else begin
        want = pending_results.pop_front();
        if (out_data.rx !== want.rx || out_data.ry !== want.ry ||
            out_data.rz !== want.rz || out_data.scalar_out !== want.scalar_out ||
            out_data.div_error !== want.div_error) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: exp r=%h %h %h s=%h e=%b got r=%h %h %h s=%h e=%b",
                     want.rx, want.ry, want.rz, want.scalar_out, want.div_error,
                     out_data.rx, out_data.ry, out_data.rz, out_data.scalar_out,
                     out_data.div_error);
        end
      end
    end
  end

  // watchdog
  initial begin
    #5ms;
    $display("FAIL vector3_arith_unit");
    $finish;
  end

  initial begin
    v3a_in_t w;
    int      phase_items;
    mismatches = 0;
    idle_pct   = 0;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed table: corners, every operation, two undefined codes, zero-divisor and zero-vector cases
    add_row(make_word(OP_DOT, 0, 0, 0, 0, 0, 0, 0), 1, '0);
    add_row(make_word(OP_DOT, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 0), 1,
            v3a_out_t'{32'h0, 32'h0, 32'h0, Q_MAX, 1'b0});
    add_row(make_word(OP_DOT, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN), 0, '0);
    add_row(make_word(OP_CROSS, Q_ONE, 0, 0, 0, Q_ONE, 0, 0), 1,
            v3a_out_t'{32'h0, 32'h0, Q_ONE, 32'h0, 1'b0});
    add_row(make_word(OP_CROSS, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 0), 0, '0);
    add_row(make_word(OP_LENGTH, 32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0, 0), 1,
            v3a_out_t'{32'h0, 32'h0, 32'h0, 32'h0005_0000, 1'b0});
    add_row(make_word(OP_LENGTH, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0, 0), 1,
            v3a_out_t'{32'h0, 32'h0, 32'h0, Q_MAX, 1'b0});
    add_row(make_word(OP_NORM, 0, 0, 0, Q_MAX, Q_MIN, 1, 1), 1, '0);
    add_row(make_word(OP_NORM, 32'h0003_0000, 32'hfffc_0000, 0, 0, 0, 0, 0), 0, '0);
    add_row(make_word(OP_NORM, 1, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(make_word(OP_SCALE, Q_MIN, Q_MAX, 1, 0, 0, 0, Q_MIN), 0, '0);
    add_row(make_word(OP_SCALE, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0, Q_MIN), 1,
            v3a_out_t'{Q_MAX, Q_MAX, Q_MAX, 32'h0, 1'b0});
    add_row(make_word(OP_MUL, Q_ONE, 32'hffff_ffff, 0, Q_ONE, 1, 0, 0), 1,
            v3a_out_t'{Q_ONE, 32'hffff_ffff, 32'h0, 32'h0, 1'b0});
    add_row(make_word(OP_ADD, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 0), 1,
            v3a_out_t'{Q_MAX, Q_MAX, Q_MAX, 32'h0, 1'b0});
    add_row(make_word(OP_ADD, Q_MIN, 5, Q_MAX, Q_MIN, 7, Q_MIN, 0), 0, '0);
    add_row(make_word(OP_DIVS, 1, 2, 3, 0, 0, 0, 0), 1,
            v3a_out_t'{32'h0, 32'h0, 32'h0, 32'h0, 1'b1});
    add_row(make_word(OP_DIVS, Q_MIN, Q_MAX, 32'h0001_8000, 0, 0, 0, 32'hffff_ffff), 0, '0);
    add_row(make_word(OP_DIVS, 32'h0007_0000, 32'hfff9_0000, 1, 0, 0, 0, 32'h0002_0000),
            0, '0);
    add_row(make_word(OP_DIVE, 1, 2, 3, 4, 5, 0, 9), 1,
            v3a_out_t'{32'h0, 32'h0, 32'h0, 32'h0, 1'b1});
    add_row(make_word(OP_DIVE, 1, 2, 3, 0, 5, 6, 9), 1,
            v3a_out_t'{32'h0, 32'h0, 32'h0, 32'h0, 1'b1});
    add_row(make_word(OP_DIVE, Q_MIN, Q_MAX, 32'hfffd_0000, 32'hffff_ffff, 1, Q_MIN, 0),
            0, '0);
    add_row(make_word(OP_SUB, Q_MIN, Q_MAX, 0, Q_MAX, Q_MIN, 0, 0), 1,
            v3a_out_t'{Q_MIN, Q_MAX, 32'h0, 32'h0, 1'b0});
    add_row(make_word(4'd10, 1, 2, 3, 4, 5, 6, 7), 1, '0);
    add_row(make_word(4'd15, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX), 1, '0);

    foreach (directed_rows[i])
      send_word(directed_rows[i].word,
                directed_rows[i].typed ? directed_rows[i].result
                                       : vector_result(directed_rows[i].word));

    // random traffic over the idling phases: none, heavy, light, none
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        1:       idle_pct = 87;
        2:       idle_pct = 6;
        default: idle_pct = 0;
      endcase
      phase_items = (phase == 1) ? 250 : 400;
      repeat (phase_items) begin
        w = random_word();
        send_word(w, vector_result(w));
      end
    end
    start <= 1'b0;

    // drain, then let the pipe run out
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 20) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS vector3_arith_unit");
    end else begin
      $display("FAIL vector3_arith_unit");
    end
    $finish;
  end

endmodule
